// ===== rtl/rau_pkg.sv =====
// rational arithmetic unit package: operand width, operation codes and item structs
// no dependencies
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                      action;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic [OPERAND_WIDTH-1:0]        a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic [OPERAND_WIDTH-1:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [2*OPERAND_WIDTH:0] res_num;
    logic [2*OPERAND_WIDTH-1:0]      res_den;
    logic                            error;
  } out_item_t;

endpackage

// ===== rtl/rau_divider.sv =====
// rau_divider: restoring divider, one quotient bit per cycle
// depends on nothing; used by rational_arithmetic_unit
module rau_divider #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  // one shift and trial subtract per cycle
  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {r_r, q_r[W-1]};
    trial    = shifted - {1'b0, d_r};
    if (go) begin
      q_nxt   = dividend;
      r_nxt   = '0;
      d_nxt   = divisor;
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[W]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = shifted[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

`ifndef ASSERT_OFF
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r)) else $error("done without run");
  a_no_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("run still set at done");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!run_r && !go) |=> !run_r) else $error("run rose without go");
`endif

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: top level, sequencer around a shared multiplier
// and a shared serial divider; depends on rau_pkg and rau_divider
//
// One item at a time: pulse start while busy is low; the result shows on
// out_item for one cycle with out_valid high and cannot be held off. An item
// runs the multiply steps M1 and M2, plus M3 for add and subtract, then the
// Euclidean loop: each remainder step is one division on the shared serial
// divider, 2*OPERAND_WIDTH+2 bits wide (start, quotient bits, done), then two
// more divisions of the same width for the reduction. Error items go from M1
// straight to the result, and zero numerators skip the divisions. busy is
// low again in the cycle that shows the result.
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rau_pkg::out_item_t out_item
);

  localparam int W  = rau_pkg::OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int DW = PW + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_GW   = 4'd6;
  localparam logic [3:0] S_RN   = 4'd7;
  localparam logic [3:0] S_RNW  = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_RDW  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]      st_r, st_nxt;
  logic [1:0]      op_r;
  logic [W-1:0]    am_r, ad_r, bm_r, bd_r;
  logic            an_r, bn_r, neg_r;
  logic [PW-1:0]   t1_r, t2_r, den_r;
  logic [PW:0]     mag_r;
  logic [PW:0]     x_r, y_r;
  logic [PW:0]     q1_r;
  logic            err_r;
  logic            ov_r;
  rau_pkg::out_item_t oi_r;

  // operand magnitudes at the input
  logic [W-1:0] a_raw, b_raw, a_mag, b_mag;
  assign a_raw = W'(in_item.a_num);
  assign b_raw = W'(in_item.b_num);
  assign a_mag = a_raw[W-1] ? (~a_raw + W'(1)) : a_raw;
  assign b_mag = b_raw[W-1] ? (~b_raw + W'(1)) : b_raw;

  // shared multiplier
  logic [W-1:0]  mx, my;
  logic [PW-1:0] prod;
  assign prod = PW'(mx) * PW'(my);
  always_comb begin
    mx = am_r;
    my = bd_r;
    case (st_r)
      S_M1: begin
        mx = am_r;
        my = (op_r == rau_pkg::OP_MUL) ? bm_r : bd_r;
      end
      S_M2: begin
        mx = (op_r == rau_pkg::OP_DIV) ? bm_r : bd_r;
        my = ad_r;
      end
      S_M3: begin
        mx = bm_r;
        my = ad_r;
      end
      default: begin
        mx = am_r;
        my = bd_r;
      end
    endcase
  end

  // shared divider
  logic          dgo;
  logic [DW-1:0] ddnd, ddvs, dq, drm;
  logic          ddone;
  always_comb begin
    ddnd = DW'(x_r);
    ddvs = DW'(y_r);
    if (st_r == S_RN) begin
      ddnd = DW'(mag_r);
      ddvs = DW'(x_r);
    end else if (st_r == S_RD) begin
      ddnd = DW'(den_r);
      ddvs = DW'(x_r);
    end
  end
  assign dgo = (st_r == S_GCD && mag_r != '0 && y_r != '0) || st_r == S_RN ||
               st_r == S_RD;

  rau_divider #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .dividend(ddnd), .divisor(ddvs),
    .done(ddone), .quot(dq), .rem(drm)
  );

  logic s2;
  assign s2 = (op_r == rau_pkg::OP_SUB) ? !bn_r : bn_r;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (start) st_nxt = S_M1;
      S_M1: begin
        if (err_r) st_nxt = S_OUT;
        else st_nxt = S_M2;
      end
      S_M2: st_nxt = (op_r[1]) ? S_COMB : S_M3;
      S_M3: st_nxt = S_COMB;
      S_COMB: st_nxt = S_GCD;
      S_GCD: begin
        if (mag_r == '0) st_nxt = S_OUT;
        else if (y_r == '0) st_nxt = S_RN;
        else st_nxt = S_GW;
      end
      S_GW:  if (ddone) st_nxt = S_GCD;
      S_RN:  st_nxt = S_RNW;
      S_RNW: if (ddone) st_nxt = S_RD;
      S_RD:  st_nxt = S_RDW;
      S_RDW: if (ddone) st_nxt = S_OUT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= (st_r == S_OUT);
    end
    case (st_r)
      S_IDLE: begin
        op_r  <= in_item.action;
        am_r  <= a_mag;
        bm_r  <= b_mag;
        ad_r  <= in_item.a_den;
        bd_r  <= in_item.b_den;
        an_r  <= a_raw[W-1];
        bn_r  <= b_raw[W-1];
        err_r <= (in_item.a_den == '0) || (in_item.b_den == '0) ||
                 (in_item.action == rau_pkg::OP_DIV && b_mag == '0);
      end
      S_M1: t1_r <= prod;
      // denominator product for every operation
      S_M2: den_r <= prod;
      // cross product of the second numerator for add and subtract
      S_M3: t2_r <= prod;
      S_COMB: begin
        if (op_r[1]) begin
          mag_r <= {1'b0, t1_r};
          neg_r <= an_r ^ bn_r;
          x_r   <= {1'b0, t1_r};
        end else if (an_r == s2) begin
          mag_r <= {1'b0, t1_r} + {1'b0, t2_r};
          neg_r <= an_r;
          x_r   <= {1'b0, t1_r} + {1'b0, t2_r};
        end else if (t1_r >= t2_r) begin
          mag_r <= {1'b0, t1_r - t2_r};
          neg_r <= an_r;
          x_r   <= {1'b0, t1_r - t2_r};
        end else begin
          mag_r <= {1'b0, t2_r - t1_r};
          neg_r <= s2;
          x_r   <= {1'b0, t2_r - t1_r};
        end
        y_r <= {1'b0, den_r};
      end
      S_GW: if (ddone) begin
        x_r <= y_r;
        y_r <= drm[PW:0];
      end
      S_RNW: if (ddone) q1_r <= dq[PW:0];
      default: ;
    endcase
    // result register
    if (st_r == S_OUT) begin
      if (err_r || mag_r == '0) begin
        oi_r.res_num <= '0;
        oi_r.res_den <= PW'(1);
      end else begin
        oi_r.res_num <= (PW+1)'(neg_r ? (~q1_r + 1'b1) : q1_r);
        oi_r.res_den <= PW'(dq);
      end
      oi_r.error <= err_r;
    end
  end

  assign busy      = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> st_r == S_M1) else $error("start not taken");
  a_out_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
`endif

endmodule

// ===== sim/rau_checker.sv =====
// rational arithmetic unit checker: watches the item and result channels,
// predicts each reduced fraction and compares it; depends on rau_pkg
`timescale 1ns / 1ps

module rau_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  rau_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  rau_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending_count
);

  rau_pkg::out_item_t fraction_q[$];
  int mismatch_count = 0;

  // euclid on widened magnitudes
  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic rau_pkg::out_item_t reduce_fraction(input rau_pkg::in_item_t it);
    rau_pkg::out_item_t r;
    logic [63:0] am, bm, ad, bd, t1, t2, mag, den, g;
    logic an, bn, s2, neg;
    an = it.a_num[15];
    bn = it.b_num[15];
    am = an ? 64'(-$signed(64'(it.a_num))) : 64'(it.a_num);
    bm = bn ? 64'(-$signed(64'(it.b_num))) : 64'(it.b_num);
    ad = 64'(it.a_den);
    bd = 64'(it.b_den);
    r.res_num = '0;
    r.res_den = 32'd1;
    r.error = 1'b0;
    // zero denominator or division by zero
    if (ad == 0 || bd == 0 || (it.action == rau_pkg::OP_DIV && bm == 0)) begin
      r.error = 1'b1;
      return r;
    end
    case (it.action)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        t1 = am * bd;
        t2 = bm * ad;
        s2 = (it.action == rau_pkg::OP_SUB) ? !bn : bn;
        den = ad * bd;
        if (an == s2) begin
          mag = t1 + t2; neg = an;
        end else if (t1 >= t2) begin
          mag = t1 - t2; neg = an;
        end else begin
          mag = t2 - t1; neg = s2;
        end
      end
      rau_pkg::OP_MUL: begin
        mag = am * bm; den = ad * bd; neg = an ^ bn;
      end
      default: begin
        mag = am * bd; den = ad * bm; neg = an ^ bn;
      end
    endcase
    // zero numerator gives +0/1
    if (mag == 0) return r;
    g = gcd64(mag, den);
    mag = mag / g;
    den = den / g;
    r.res_num = neg ? 33'(-mag) : 33'(mag);
    r.res_den = den[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  assign pending_count = fraction_q.size();
  assign fail_count    = mismatch_count;

  always @(posedge clk) begin
    rau_pkg::out_item_t want;
    if (rst_n && start && !busy) fraction_q.push_back(reduce_fraction(in_item));
    if (rst_n && out_valid) begin
      if (fraction_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = fraction_q.pop_front();
        if (out_item.res_num !== want.res_num)
          report_mismatch($sformatf("res_num %0d, want %0d", out_item.res_num, want.res_num));
        if (out_item.res_den !== want.res_den)
          report_mismatch($sformatf("res_den %0d, want %0d", out_item.res_den, want.res_den));
        if (out_item.error !== want.error)
          report_mismatch($sformatf("error %0b, want %0b", out_item.error, want.error));
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
// rational arithmetic unit testbench top: clock, reset, item stimulus, verdict
// depends on rau_pkg, rational_arithmetic_unit and rau_checker
`timescale 1ns / 1ps

module testbench;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  rau_pkg::in_item_t  in_item;
  logic               out_valid;
  rau_pkg::out_item_t out_item;
  int                 fail_count;
  int                 pending_count;
  int                 idle_pct;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  rau_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle with start low, then hold start until the item is taken;
  // busy is sampled mid-cycle so the accepting edge is seen exactly
  task automatic send_item(input rau_pkg::in_item_t it);
    logic taken;
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // wait until every outstanding item has its result
  task automatic drain();
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_num();
    case ($urandom_range(5, 0))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(16, 0)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_den();
    case ($urandom_range(9, 0))
      0: return 16'd0;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(12, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rau_pkg::in_item_t rand_item();
    rau_pkg::in_item_t it;
    it.action = 2'($urandom_range(3, 0));
    it.a_num = rand_num();
    it.a_den = rand_den();
    it.b_num = rand_num();
    it.b_den = rand_den();
    return it;
  endfunction

  initial begin
    rau_pkg::in_item_t it;
    logic [1:0] ops[4];
    ops = '{rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_DIV};
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, error cases and zero numerators for every operation
    foreach (ops[i]) begin
      send_item('{ops[i], 16'sh8000, 16'hffff, 16'sh8000, 16'hffff});
      send_item('{ops[i], 16'sh7fff, 16'd1, 16'sh8000, 16'd1});
      send_item('{ops[i], 16'sd3, 16'd0, 16'sd5, 16'd7});
      send_item('{ops[i], 16'sd0, 16'd5, 16'sd0, 16'd9});
      send_item('{ops[i], -16'sd6, 16'd4, 16'sd9, 16'd6});
    end
    send_item('{rau_pkg::OP_SUB, 16'sd2, 16'd3, 16'sd2, 16'd3});
    send_item('{rau_pkg::OP_ADD, 16'sd1, 16'd2, 16'sd7, 16'd0});

    // wait for all results before the random part
    start <= 1'b0;
    drain();

    idle_pct = 32;
    repeat (400) send_item(rand_item());
    idle_pct = 71;
    repeat (400) send_item(rand_item());
    idle_pct = 0;
    repeat (420) send_item(rand_item());

    start <= 1'b0;
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // slow divider: timeout for the whole run
  initial begin
    #400ms;
    $display("Verification failed");
    $finish;
  end
endmodule
